### hdl/plmm_pkg.sv
package plmm_pkg;

    localparam int NUM_CH  = 16;
    localparam int NUM_MEM = 16;
    localparam int CH_W    = 4;
    localparam int MEM_W   = 4;
    localparam int PAIR_W  = 2 * MEM_W;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_ACTIVE = 2'd1;
    localparam logic [1:0] CFG_OWNED  = 2'd2;
    localparam logic [1:0] CFG_MEMBER = 2'd3;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic             ready;
        logic             clr;
        logic             step;
        logic [MEM_W-1:0] li;
        logic [MEM_W-1:0] tj;
        logic             emit;
        logic [CH_W-1:0]  ch;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_done;
        logic ch_emit;
        logic out_free;
    } t_dp_sts;

endpackage

### hdl/plmm_ctrl.sv
module plmm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plmm_pkg::t_dp_sts  i_sts,
    output plmm_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MIX   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [plmm_pkg::PAIR_W-1:0] DRAIN_LAST = plmm_pkg::PAIR_W'(3);

    logic [1:0]                  r_state, n_state;
    logic [plmm_pkg::PAIR_W-1:0] r_cnt, n_cnt;
    logic                        adv;

    assign adv = !i_sts.ch_emit || i_sts.out_free;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_sts.frame_done) begin
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DRAIN_LAST) begin
                    n_state = ST_EMIT;
                    n_cnt   = '0;
                end
            end
            ST_EMIT: begin
                if (adv) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt[plmm_pkg::CH_W-1:0] == '1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        o_cmd.ready = (r_state == ST_IDLE);
        o_cmd.clr   = (r_state == ST_IDLE) && i_sts.frame_done;
        o_cmd.step  = (r_state == ST_MIX);
        o_cmd.li    = r_cnt[plmm_pkg::PAIR_W-1:plmm_pkg::MEM_W];
        o_cmd.tj    = r_cnt[plmm_pkg::MEM_W-1:0];
        o_cmd.emit  = (r_state == ST_EMIT);
        o_cmd.ch    = r_cnt[plmm_pkg::CH_W-1:0];
    end

endmodule

### hdl/plmm_dp.sv
module plmm_dp #(
    parameter int SAMPLE_BITS = 24,
    parameter int GAIN_BITS   = 16,
    parameter int IN_W        = 64,
    parameter int OUT_W       = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plmm_pkg::t_dp_cmd  i_cmd,
    output plmm_pkg::t_dp_sts  o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_s_tvalid,
    input  logic [IN_W-1:0]    i_s_tdata,
    input  logic               i_s_tuser,
    input  logic               i_s_tlast,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [OUT_W-1:0]   o_m_tdata,
    output logic               o_m_tlast
);

    localparam int CW   = plmm_pkg::CH_W;
    localparam int NCH  = plmm_pkg::NUM_CH;
    localparam int NMEM = plmm_pkg::NUM_MEM;
    localparam int FRAC = GAIN_BITS - 4;
    localparam int PW   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int AW   = PW + 2 * plmm_pkg::MEM_W;

    localparam int O_LINE = 4;
    localparam int O_EP   = 8;
    localparam int O_TALK = 12;
    localparam int O_CAP  = 13;
    localparam int O_LIS  = 17;
    localparam int O_PLAY = 18;
    localparam int O_GAIN = 22;
    localparam int O_MUTE = O_GAIN + GAIN_BITS;
    localparam int O_SMP  = O_MUTE + 1;

    typedef struct packed {
        logic [3:0]           line;
        logic [3:0]           ep;
        logic                 talk;
        logic [CW-1:0]        cap;
        logic                 listen;
        logic [CW-1:0]        play;
        logic [GAIN_BITS-1:0] gain;
        logic                 mute;
    } t_member;

    logic           r_en;
    logic [4:0]     r_act;
    logic [NCH-1:0] r_owned;
    logic [4:0]     r_nmem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_act   <= 5'd16;
            r_owned <= '0;
            r_nmem  <= 5'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plmm_pkg::CFG_ENABLE: r_en    <= i_cfg_data[0];
                plmm_pkg::CFG_ACTIVE: r_act   <= i_cfg_data[4:0];
                plmm_pkg::CFG_OWNED:  r_owned <= i_cfg_data[NCH-1:0];
                plmm_pkg::CFG_MEMBER: r_nmem  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [4:0]     act_eff, nmem_eff;
    logic [NCH-1:0] act_mask, emit_mask;

    assign act_eff  = (r_act > 5'd16) ? 5'd16 : r_act;
    assign nmem_eff = (r_nmem > 5'd16) ? 5'd16 : r_nmem;

    for (genvar c = 0; c < NCH; c++) begin : g_act
        assign act_mask[c] = (5'(c) < act_eff);
    end
    assign emit_mask = act_mask & r_owned;

    logic     in_acc;
    t_member  wr_m;

    assign in_acc = i_s_tvalid && i_cmd.ready;

    always_comb begin
        wr_m.line   = i_s_tdata[O_LINE +: 4];
        wr_m.ep     = i_s_tdata[O_EP +: 4];
        wr_m.talk   = i_s_tdata[O_TALK];
        wr_m.cap    = i_s_tdata[O_CAP +: CW];
        wr_m.listen = i_s_tdata[O_LIS];
        wr_m.play   = i_s_tdata[O_PLAY +: CW];
        wr_m.gain   = i_s_tdata[O_GAIN +: GAIN_BITS];
        wr_m.mute   = i_s_tdata[O_MUTE];
    end

    t_member r_mem [NMEM];
    t_member r_li, r_tj;
    logic    r_v0, r_in0;

    always_ff @(posedge i_clk) begin
        if (in_acc && i_s_tuser == plmm_pkg::KIND_ENTRY) begin
            r_mem[i_s_tdata[3:0]] <= wr_m;
        end
        r_li <= r_mem[i_cmd.li];
        r_tj <= r_mem[i_cmd.tj];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_in0 <= 1'b0;
        end else begin
            r_v0  <= i_cmd.step;
            r_in0 <= ({1'b0, i_cmd.li} < nmem_eff) && ({1'b0, i_cmd.tj} < nmem_eff);
        end
    end

    logic signed [SAMPLE_BITS-1:0] r_fs [NCH];
    logic [NCH-1:0]                r_fs_vld;
    logic [4:0]                    r_cc;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic                          smp_acc;

    assign smp_acc = in_acc && i_s_tuser == plmm_pkg::KIND_SAMPLE;

    always_ff @(posedge i_clk) begin
        if (smp_acc && !r_cc[4]) begin
            r_fs[r_cc[CW-1:0]] <= i_s_tdata[O_SMP +: SAMPLE_BITS];
        end
        r_smp <= r_fs_vld[r_tj.cap] ? r_fs[r_tj.cap] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_vld <= '0;
            r_cc     <= '0;
        end else if (smp_acc) begin
            if (!r_cc[4]) begin
                r_fs_vld[r_cc[CW-1:0]] <= 1'b1;
            end
            if (i_s_tlast) begin
                r_cc <= '0;
            end else if (!r_cc[4]) begin
                r_cc <= r_cc + 1'b1;
            end
        end
    end

    logic                 r_v1;
    logic [GAIN_BITS-1:0] r_g1;
    logic [CW-1:0]        r_play1, r_play2;
    logic                 hit;

    assign hit = r_v0 && r_in0 && r_li.listen && r_tj.talk && !r_tj.mute
              && ({1'b0, r_tj.cap} < act_eff)
              && (r_tj.line == r_li.line) && (r_tj.ep != r_li.ep);

    always_ff @(posedge i_clk) begin
        r_g1    <= r_tj.gain;
        r_play1 <= r_li.play;
    end

    logic signed [PW-1:0] r_prod;
    logic                 r_v2;

    always_ff @(posedge i_clk) begin
        r_prod  <= PW'(r_smp) * $signed({1'b0, r_g1});
        r_play2 <= r_play1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= hit;
            r_v2 <= r_v1;
        end
    end

    logic signed [AW-1:0] r_acc [NCH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            for (int c = 0; c < NCH; c++) begin
                r_acc[c] <= '0;
            end
        end else if (r_v2) begin
            r_acc[r_play2] <= r_acc[r_play2] + AW'(r_prod);
        end
    end

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC - 1);
    localparam logic signed [AW-1:0] SMAX = (AW'(1) <<< (SAMPLE_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);

    logic signed [AW-1:0]          rnd;
    logic signed [SAMPLE_BITS-1:0] sat;
    logic [NCH-1:0]                above;
    logic                          out_free, load;

    always_comb begin
        rnd = (r_acc[i_cmd.ch] + HALF) >>> FRAC;
        if (rnd > SMAX) begin
            sat = SAMPLE_BITS'(SMAX);
        end else if (rnd < SMIN) begin
            sat = SAMPLE_BITS'(SMIN);
        end else begin
            sat = SAMPLE_BITS'(rnd);
        end
    end

    assign above    = emit_mask >> i_cmd.ch >> 1;
    assign out_free = !o_m_tvalid || i_m_tready;
    assign load     = i_cmd.emit && emit_mask[i_cmd.ch] && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (load) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_m_tdata <= OUT_W'({sat, i_cmd.ch});
            o_m_tlast <= (above == '0);
        end
    end

    always_comb begin
        o_sts.frame_done = smp_acc && i_s_tlast && r_en;
        o_sts.ch_emit    = emit_mask[i_cmd.ch];
        o_sts.out_free   = out_free;
    end

endmodule

### hdl/party_line_mix_minus_mixer_unit.sv
// Party-line intercom mixer with mix-minus. Member table writes (tuser 0) and
// capture samples (tuser 1) are taken one per cycle while idle. The last sample
// of a frame (tlast) starts the mix if the mixer is enabled: all 256
// listener/talker member pairs pass one per cycle through a four-stage
// multiply-accumulate datapath into one accumulator per playback channel, then
// owned active channels are sent in ascending order by a scan that steps one
// channel per cycle unless the output stalls. The time a frame costs after its
// last sample is set by the single shared multiplier, pair counter and emit
// scan. Member table entries read before being written give undefined results.
module party_line_mix_minus_mixer_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int GAIN_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [15:0]            i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index, line_id, endpoint_num, talk_valid, talk_ch,
    // listen_valid, listen_ch, gain, mute, sample
    input  logic [((23 + GAIN_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                   s_axis_tuser,  // kind
    input  logic                   s_axis_tlast,  // last_in_frame
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_channel, out_sample
    output logic [((4 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                   m_axis_tlast   // last
);

    localparam int IN_W  = ((23 + GAIN_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((4 + SAMPLE_BITS + 7) / 8) * 8;

    plmm_pkg::t_dp_cmd cmd;
    plmm_pkg::t_dp_sts sts;

    plmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    plmm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .GAIN_BITS   (GAIN_BITS),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tlast  (s_axis_tlast),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

    assign s_axis_tready = cmd.ready;

endmodule

### hdl/plmm_checker.sv
module plmm_checker #(
    parameter int IN_W  = 64,
    parameter int OUT_W = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tuser,
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
        else $error("table write left input stalled");

    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("mid-frame item left input stalled");

endmodule

bind party_line_mix_minus_mixer_unit plmm_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
) u_plmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
